>>> sv/cau_pkg.sv
// Shared types, opcodes and constants for the complex arithmetic unit.
`timescale 1ns / 1ps

package cau_pkg;

   // Operation codes
   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_DIV = 2'd3;

   // Status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_DIVZ = 2'd1;
   localparam logic [1:0] STAT_SAT  = 2'd2;

   // Default number of fraction bits
   localparam int FRAC_BITS_DEF = 16;

   // Quotient bits kept by the divider; anything at or above 2^DIV_QW saturates
   localparam int DIV_QW  = 33;
   // Divider depth: one setup register plus one register per quotient bit
   localparam int DIV_LAT = DIV_QW + 1;

   // Exact width of a two-product sum
   localparam int WIDE_W = 65;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] left_real;
      logic signed [31:0] left_imag;
      logic signed [31:0] right_real;
      logic signed [31:0] right_imag;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_real;
      logic signed [31:0] result_imag;
      logic [1:0]         status;
   } rsp_type;

   // Divider result for one part
   typedef struct packed {
      logic [DIV_QW-1:0] quot;
      logic              ovf;
      logic              neg;
   } div_res_type;

   // Payload carried alongside the divider
   typedef struct packed {
      logic [1:0]               cmd;
      logic                     zero;
      logic signed [WIDE_W-1:0] val_re;
      logic signed [WIDE_W-1:0] val_im;
   } side_type;

endpackage

>>> sv/cau_div.sv
// Pipelined restoring divider: one quotient bit per stage, scaled by 2^FRAC_BITS.
`timescale 1ns / 1ps

module cau_div #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [63:0]          num_mag,
   input  logic                 num_neg,
   input  logic [63:0]          den,
   output cau_pkg::div_res_type res
);
   import cau_pkg::*;

   localparam int REM_W  = 65;
   localparam int LOW_HI = DIV_QW - FRAC_BITS;

   logic [REM_W-1:0]  rem_ff [0:DIV_QW];
   logic [DIV_QW-1:0] q_ff   [0:DIV_QW];
   logic [DIV_QW-1:0] low_ff [0:DIV_QW];
   logic [63:0]       den_ff [0:DIV_QW];
   logic              neg_ff [0:DIV_QW];
   logic              ovf_ff [0:DIV_QW];

   logic [63:0]       hi_part;
   logic [DIV_QW-1:0] low_in;

   // Setup: high part of the scaled dividend seeds the remainder
   always_comb begin
      hi_part = num_mag >> LOW_HI;
      low_in  = {num_mag[LOW_HI-1:0], {FRAC_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= REM_W'(hi_part);
         q_ff[0]   <= '0;
         low_ff[0] <= low_in;
         den_ff[0] <= den;
         neg_ff[0] <= num_neg;
         ovf_ff[0] <= (hi_part >= den);
      end
   end

   // One compare and subtract per stage
   for (genvar k = 0; k < DIV_QW; k++) begin : g_step
      logic [REM_W-1:0] trial;
      logic             ge;

      always_comb begin
         trial = {rem_ff[k][REM_W-2:0], low_ff[k][DIV_QW-1-k]};
         ge    = (trial >= {1'b0, den_ff[k]});
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? (trial - {1'b0, den_ff[k]}) : trial;
            q_ff[k+1]   <= {q_ff[k][DIV_QW-2:0], ge};
            low_ff[k+1] <= low_ff[k];
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   assign res.quot = q_ff[DIV_QW];
   assign res.ovf  = ovf_ff[DIV_QW];
   assign res.neg  = neg_ff[DIV_QW];

endmodule

>>> sv/complex_arith_unit_top.sv
// Top level of the complex arithmetic unit: add, subtract, multiply, divide.
//
//  port group   dir   handshake            payload
//  req_         in    req_valid/req_stall  cau_pkg::req_type
//  rsp_         out   rsp_valid/rsp_stall  cau_pkg::rsp_type
//
// Every opcode takes the same path; one item enters each cycle while req_stall
// is low. Depth is set by the divider, one quotient bit per stage.
// Reset clears only the valid bits; data registers are not reset.
// While rsp_stall holds a waiting item, a one-entry skid register catches the
// next item leaving the pipeline; once it is full the whole pipeline freezes
// and req_stall (a register) is raised; nothing is dropped or repeated.
`timescale 1ns / 1ps

module complex_arith_unit_top #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   localparam logic signed [WIDE_W-1:0] MAX_V = WIDE_W'(64'sh7FFFFFFF);
   localparam logic signed [WIDE_W-1:0] MIN_V = -WIDE_W'(64'sh80000000);
   localparam logic [DIV_QW-1:0] POS_LIM = DIV_QW'(64'h7FFFFFFF);
   localparam logic [DIV_QW-1:0] NEG_LIM = DIV_QW'(64'h80000000);

   logic en;

   // Stage 1: input register
   req_type st1_ff;
   logic    v1_ff;

   // Stage 2: products and plain sums
   logic signed [63:0] p_ac_ff, p_bd_ff, p_bc_ff, p_ad_ff, p_cc_ff, p_dd_ff;
   logic signed [32:0] s_re_ff, s_im_ff;
   logic [1:0]         cmd2_ff;
   logic               v2_ff;
   logic signed [32:0] s_re_in, s_im_in;

   // Stage 3: combined sums and divisor
   logic signed [WIDE_W-1:0] sum_re_ff, sum_im_ff, sum_re_in, sum_im_in;
   logic [63:0]              den3_ff;
   logic [1:0]               cmd3_ff;
   logic                     v3_ff;

   // Stage 4: rounded values and magnitudes
   logic signed [WIDE_W-1:0] val_re_ff, val_im_ff;
   logic [63:0]              mag_re_ff, mag_im_ff, den4_ff;
   logic                     neg_re_ff, neg_im_ff, zero4_ff;
   logic [1:0]               cmd4_ff;
   logic                     v4_ff;

   // Side payload alongside the divider
   side_type side_ff [0:DIV_LAT-1];
   logic     sv_ff   [0:DIV_LAT-1];

   div_res_type div_re, div_im;

   // Output register and skid register
   rsp_type rsp_ff, rsp_in, skid_ff;
   logic    out_v_ff, out_v_in;
   logic    skid_v_ff, skid_v_in;

   // Global advance: freeze only while the skid register holds an item
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = rsp_ff;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
      end else if (en) begin
         v1_ff    <= req_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
      end
   end

   for (genvar k = 0; k < DIV_LAT; k++) begin : g_side
      if (k == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset) begin
               sv_ff[k] <= 1'b0;
            end else if (en) begin
               sv_ff[k] <= v4_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               side_ff[k].cmd    <= cmd4_ff;
               side_ff[k].zero   <= zero4_ff;
               side_ff[k].val_re <= val_re_ff;
               side_ff[k].val_im <= val_im_ff;
            end
         end
      end else begin : g_tail
         always_ff @(posedge clock) begin
            if (reset) begin
               sv_ff[k] <= 1'b0;
            end else if (en) begin
               sv_ff[k] <= sv_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               side_ff[k] <= side_ff[k-1];
            end
         end
      end
   end

   // Stage 1 capture
   always_ff @(posedge clock) begin
      if (en) begin
         st1_ff <= req_data;
      end
   end

   // Stage 2: six products, add or subtract
   always_comb begin
      if (st1_ff.cmd == CMD_SUB) begin
         s_re_in = 33'(st1_ff.left_real) - 33'(st1_ff.right_real);
         s_im_in = 33'(st1_ff.left_imag) - 33'(st1_ff.right_imag);
      end else begin
         s_re_in = 33'(st1_ff.left_real) + 33'(st1_ff.right_real);
         s_im_in = 33'(st1_ff.left_imag) + 33'(st1_ff.right_imag);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ac_ff <= 64'(st1_ff.left_real) * 64'(st1_ff.right_real);
         p_bd_ff <= 64'(st1_ff.left_imag) * 64'(st1_ff.right_imag);
         p_bc_ff <= 64'(st1_ff.left_imag) * 64'(st1_ff.right_real);
         p_ad_ff <= 64'(st1_ff.left_real) * 64'(st1_ff.right_imag);
         p_cc_ff <= 64'(st1_ff.right_real) * 64'(st1_ff.right_real);
         p_dd_ff <= 64'(st1_ff.right_imag) * 64'(st1_ff.right_imag);
         s_re_ff <= s_re_in;
         s_im_ff <= s_im_in;
         cmd2_ff <= st1_ff.cmd;
      end
   end

   // Stage 3: exact product sums for multiply and divide, plain sums otherwise
   always_comb begin
      case (cmd2_ff)
         CMD_MUL: begin
            sum_re_in = WIDE_W'(p_ac_ff) - WIDE_W'(p_bd_ff);
            sum_im_in = WIDE_W'(p_bc_ff) + WIDE_W'(p_ad_ff);
         end
         CMD_DIV: begin
            sum_re_in = WIDE_W'(p_ac_ff) + WIDE_W'(p_bd_ff);
            sum_im_in = WIDE_W'(p_bc_ff) - WIDE_W'(p_ad_ff);
         end
         default: begin
            sum_re_in = WIDE_W'(s_re_ff);
            sum_im_in = WIDE_W'(s_im_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_re_ff <= sum_re_in;
         sum_im_ff <= sum_im_in;
         den3_ff   <= 64'(p_cc_ff) + 64'(p_dd_ff);
         cmd3_ff   <= cmd2_ff;
      end
   end

   // Stage 4: floor shift for products, sign and magnitude for the divider
   always_ff @(posedge clock) begin
      if (en) begin
         if (cmd3_ff == CMD_MUL) begin
            val_re_ff <= sum_re_ff >>> FRAC_BITS;
            val_im_ff <= sum_im_ff >>> FRAC_BITS;
         end else begin
            val_re_ff <= sum_re_ff;
            val_im_ff <= sum_im_ff;
         end
         neg_re_ff <= sum_re_ff[WIDE_W-1];
         neg_im_ff <= sum_im_ff[WIDE_W-1];
         mag_re_ff <= sum_re_ff[WIDE_W-1] ? 64'(-sum_re_ff) : 64'(sum_re_ff);
         mag_im_ff <= sum_im_ff[WIDE_W-1] ? 64'(-sum_im_ff) : 64'(sum_im_ff);
         den4_ff   <= den3_ff;
         zero4_ff  <= (den3_ff == 64'd0);
         cmd4_ff   <= cmd3_ff;
      end
   end

   cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
      .clock   (clock),
      .en      (en),
      .num_mag (mag_re_ff),
      .num_neg (neg_re_ff),
      .den     (den4_ff),
      .res     (div_re)
   );

   cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
      .clock   (clock),
      .en      (en),
      .num_mag (mag_im_ff),
      .num_neg (neg_im_ff),
      .den     (den4_ff),
      .res     (div_im)
   );

   // Final stage: saturate and build status
   always_comb begin
      logic     sat_re, sat_im;
      side_type sd;
      sd     = side_ff[DIV_LAT-1];
      sat_re = 1'b0;
      sat_im = 1'b0;
      rsp_in = '0;
      if (sd.cmd == CMD_DIV) begin
         sat_re = div_re.ovf || (div_re.neg ? (div_re.quot > NEG_LIM)
                                            : (div_re.quot > POS_LIM));
         sat_im = div_im.ovf || (div_im.neg ? (div_im.quot > NEG_LIM)
                                            : (div_im.quot > POS_LIM));
         if (sat_re) begin
            rsp_in.result_real = div_re.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
         end else begin
            rsp_in.result_real = div_re.neg ? 32'(-div_re.quot) : 32'(div_re.quot);
         end
         if (sat_im) begin
            rsp_in.result_imag = div_im.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
         end else begin
            rsp_in.result_imag = div_im.neg ? 32'(-div_im.quot) : 32'(div_im.quot);
         end
      end else begin
         sat_re = (sd.val_re > MAX_V) || (sd.val_re < MIN_V);
         sat_im = (sd.val_im > MAX_V) || (sd.val_im < MIN_V);
         if (sat_re) begin
            rsp_in.result_real = sd.val_re[WIDE_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
         end else begin
            rsp_in.result_real = sd.val_re[31:0];
         end
         if (sat_im) begin
            rsp_in.result_imag = sd.val_im[WIDE_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
         end else begin
            rsp_in.result_imag = sd.val_im[31:0];
         end
      end
      rsp_in.status = (sat_re || sat_im) ? STAT_SAT : STAT_OK;
      // Zero divisor overrides everything
      if (sd.cmd == CMD_DIV && sd.zero) begin
         rsp_in.result_real = '0;
         rsp_in.result_imag = '0;
         rsp_in.status      = STAT_DIVZ;
      end
   end

   // Output and skid occupancy
   always_comb begin
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      if (skid_v_ff) begin
         if (!rsp_stall) begin
            out_v_in  = 1'b1;
            skid_v_in = 1'b0;
         end
      end else if (out_v_ff && rsp_stall) begin
         skid_v_in = sv_ff[DIV_LAT-1];
      end else begin
         out_v_in = sv_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   // Output and skid data
   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (!rsp_stall) begin
            rsp_ff <= skid_ff;
         end
      end else if (out_v_ff && rsp_stall) begin
         skid_ff <= rsp_in;
      end else begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
